// ===== hw/rtl/stt_pkg.sv =====
// Shared types and constants of the software timer table.
// Request/response payload structs, opcodes, and the controller/datapath link.
// No dependencies.
package stt_pkg;

  localparam int unsigned TaskSlotsDef = 8;
  localparam int unsigned TickW        = 32;
  localparam int unsigned IdW          = 8;
  localparam int unsigned SlotFieldW   = 3;
  localparam int unsigned EntryW       = IdW + 2 * TickW;

  localparam logic [1:0] OpTick  = 2'd0;
  localparam logic [1:0] OpStart = 2'd1;
  localparam logic [1:0] OpStop  = 2'd2;

  localparam logic [1:0] KindStart = 2'd0;
  localparam logic [1:0] KindStop  = 2'd1;
  localparam logic [1:0] KindFired = 2'd2;

  localparam logic StatusOk   = 1'b0;
  localparam logic StatusFull = 1'b1;

  typedef struct packed {
    logic [1:0]       op;
    logic [IdW-1:0]   task_id;
    logic [TickW-1:0] ticks;
    logic             run_once;
  } in_req_t;

  typedef struct packed {
    logic [1:0]            kind;
    logic                  status;
    logic [IdW-1:0]        result_id;
    logic [SlotFieldW-1:0] slot;
    logic                  last;
  } out_rsp_t;

  typedef struct packed {
    logic [IdW-1:0]   id;
    logic [TickW-1:0] delay;
    logic [TickW-1:0] rem;
  } entry_t;

  typedef struct packed {
    logic load_item;
    logic tick_inc;
    logic scan_clr;
    logic scan_inc;
    logic alloc;
    logic div_start;
    logic div_step;
    logic ins_commit;
    logic stop_eval;
    logic tick_commit;
    logic push_resp;
    logic push_pend;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       full;
    logic       need_div;
    logic       scan_last;
    logic       div_done;
    logic       tick_block;
    logic       out_free;
    logic       pend_valid;
  } sts_t;

endpackage

// ===== hw/rtl/stt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module stt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/stt_ctrl.sv =====
// Controller state machine of the software timer table.
// Sequences tick scan, start allocation/division, stop scan and replies.
// Depends on stt_pkg.
module stt_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  stt_pkg::sts_t sts_i,
  output stt_pkg::cmd_t cmd_o
);

  typedef enum logic [3:0] {
    StIdle,
    StDecode,
    StTickRd,
    StTickEval,
    StTickFlush,
    StDiv,
    StInsert,
    StStopRd,
    StStopEval,
    StReply
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = StDecode;
        end
      end
      StDecode: begin
        case (sts_i.op)
          stt_pkg::OpTick: begin
            cmd_o.tick_inc = 1'b1;
            cmd_o.scan_clr = 1'b1;
            state_d        = StTickRd;
          end
          stt_pkg::OpStart: begin
            cmd_o.alloc = 1'b1;
            if (sts_i.full) begin
              state_d = StReply;
            end else if (sts_i.need_div) begin
              cmd_o.div_start = 1'b1;
              state_d         = StDiv;
            end else begin
              state_d = StInsert;
            end
          end
          stt_pkg::OpStop: begin
            cmd_o.scan_clr = 1'b1;
            state_d        = StStopRd;
          end
          default: state_d = StIdle;
        endcase
      end
      StTickRd: state_d = StTickEval;
      StTickEval: begin
        if (!sts_i.tick_block) begin
          cmd_o.tick_commit = 1'b1;
          if (sts_i.scan_last) begin
            state_d = StTickFlush;
          end else begin
            cmd_o.scan_inc = 1'b1;
            state_d        = StTickRd;
          end
        end
      end
      StTickFlush: begin
        if (!sts_i.pend_valid) begin
          state_d = StIdle;
        end else if (sts_i.out_free) begin
          cmd_o.push_pend = 1'b1;
          state_d         = StIdle;
        end
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_done) begin
          state_d = StInsert;
        end
      end
      StInsert: begin
        cmd_o.ins_commit = 1'b1;
        state_d          = StReply;
      end
      StStopRd: state_d = StStopEval;
      StStopEval: begin
        cmd_o.stop_eval = 1'b1;
        if (sts_i.scan_last) begin
          state_d = StReply;
        end else begin
          cmd_o.scan_inc = 1'b1;
          state_d        = StStopRd;
        end
      end
      StReply: begin
        if (sts_i.out_free) begin
          cmd_o.push_resp = 1'b1;
          state_d         = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != StIdle);

endmodule

// ===== hw/rtl/stt_datapath.sv =====
// Datapath of the software timer table: entry RAM, slot flags, tick count,
// remainder divider, pending fired result and output register.
// Depends on stt_pkg and stt_ram.
module stt_datapath #(
  parameter int unsigned TASK_SLOTS = stt_pkg::TaskSlotsDef,
  localparam int unsigned SlotW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  stt_pkg::in_req_t  in_req_i,
  input  stt_pkg::cmd_t     cmd_i,
  output stt_pkg::sts_t     sts_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output stt_pkg::out_rsp_t out_rsp_o
);

  localparam int unsigned TickW   = stt_pkg::TickW;
  localparam int unsigned DivCntW = $clog2(TickW);

  stt_pkg::in_req_t  item_q;
  logic [TickW-1:0]  count_q;
  logic [SlotW-1:0]  scan_q;
  logic [TASK_SLOTS-1:0] used_q, once_q, done_q;
  logic [SlotW-1:0]  alloc_slot_q;
  logic              full_q;
  logic [DivCntW-1:0] div_cnt_q;
  logic [TickW-1:0]  div_rem_q, div_num_q;
  logic              pend_valid_q;
  stt_pkg::out_rsp_t pend_q;
  logic              out_valid_q;
  stt_pkg::out_rsp_t out_q;

  logic [SlotW-1:0]  free_idx;
  logic              full;
  logic              out_free;
  logic              ram_we;
  logic [SlotW-1:0]  ram_waddr;
  stt_pkg::entry_t   ram_wdata, rd_entry;
  logic [stt_pkg::EntryW-1:0] ram_rdata;
  logic              cur_used, cur_once, cur_done, delay_nz;
  logic [TickW-1:0]  rem_inc, rem_new;
  logic              fire_per, fire_once, fire;
  logic [TickW:0]    div_sh, div_sub;
  logic              stop_hit;
  stt_pkg::out_rsp_t fired_rsp, reply_rsp, pend_last_rsp;

  always_comb begin
    free_idx = '0;
    full     = 1'b1;
    for (int i = TASK_SLOTS - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        free_idx = SlotW'(i);
        full     = 1'b0;
      end
    end
  end

  stt_ram #(
    .WIDTH(stt_pkg::EntryW),
    .DEPTH(TASK_SLOTS)
  ) u_entry_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(scan_q),
    .rdata_o(ram_rdata)
  );

  assign rd_entry  = stt_pkg::entry_t'(ram_rdata);
  assign cur_used  = used_q[scan_q];
  assign cur_once  = once_q[scan_q];
  assign cur_done  = done_q[scan_q];
  assign delay_nz  = (rd_entry.delay != '0);
  assign rem_inc   = TickW'(rd_entry.rem + 1'b1);
  assign rem_new   = ((count_q == '0) || (rem_inc == rd_entry.delay)) ? '0 : rem_inc;
  assign fire_per  = cur_used && !cur_once && delay_nz && (rem_new == '0);
  assign fire_once = cur_used && cur_once && delay_nz && !cur_done
                     && (count_q == rd_entry.delay);
  assign fire      = fire_per || fire_once;
  assign stop_hit  = cur_used && (rd_entry.id == item_q.task_id);

  assign div_sh  = {div_rem_q, div_num_q[TickW-1]};
  assign div_sub = div_sh - {1'b0, item_q.ticks};

  always_comb begin
    ram_we    = cmd_i.ins_commit || (cmd_i.tick_commit && cur_used);
    ram_waddr = cmd_i.ins_commit ? alloc_slot_q : scan_q;
    if (cmd_i.ins_commit) begin
      ram_wdata.id    = item_q.task_id;
      ram_wdata.delay = item_q.ticks;
      ram_wdata.rem   = div_rem_q;
    end else begin
      ram_wdata.id    = rd_entry.id;
      ram_wdata.delay = rd_entry.delay;
      ram_wdata.rem   = rem_new;
    end
  end

  always_comb begin
    fired_rsp.kind      = stt_pkg::KindFired;
    fired_rsp.status    = stt_pkg::StatusOk;
    fired_rsp.result_id = rd_entry.id;
    fired_rsp.slot      = stt_pkg::SlotFieldW'(scan_q);
    fired_rsp.last      = 1'b0;

    reply_rsp.kind      = (item_q.op == stt_pkg::OpStop) ? stt_pkg::KindStop
                                                         : stt_pkg::KindStart;
    reply_rsp.status    = (item_q.op == stt_pkg::OpStart) ? full_q : stt_pkg::StatusOk;
    reply_rsp.result_id = item_q.task_id;
    reply_rsp.slot      = ((item_q.op == stt_pkg::OpStart) && !full_q)
                          ? stt_pkg::SlotFieldW'(alloc_slot_q) : '0;
    reply_rsp.last      = 1'b1;

    pend_last_rsp      = pend_q;
    pend_last_rsp.last = 1'b1;
  end

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      item_q <= in_req_i;
    end
    if (cmd_i.alloc) begin
      alloc_slot_q <= free_idx;
      full_q       <= full;
    end
    if (cmd_i.div_start) begin
      div_num_q <= count_q;
      div_rem_q <= '0;
    end else if (cmd_i.div_step) begin
      div_num_q <= {div_num_q[TickW-2:0], 1'b0};
      div_rem_q <= div_sub[TickW] ? div_sh[TickW-1:0] : div_sub[TickW-1:0];
    end
    if (cmd_i.tick_commit && fire) begin
      pend_q <= fired_rsp;
    end
    if (cmd_i.push_resp) begin
      out_q <= reply_rsp;
    end else if (cmd_i.push_pend) begin
      out_q <= pend_last_rsp;
    end else if (cmd_i.tick_commit && fire && pend_valid_q) begin
      out_q <= pend_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      scan_q       <= '0;
      div_cnt_q    <= '0;
      used_q       <= '0;
      once_q       <= '0;
      done_q       <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.tick_inc) begin
        count_q <= TickW'(count_q + 1'b1);
      end
      if (cmd_i.scan_clr) begin
        scan_q <= '0;
      end else if (cmd_i.scan_inc) begin
        scan_q <= SlotW'(scan_q + 1'b1);
      end
      if (cmd_i.div_start) begin
        div_cnt_q <= '0;
      end else if (cmd_i.div_step) begin
        div_cnt_q <= DivCntW'(div_cnt_q + 1'b1);
      end
      if (cmd_i.ins_commit) begin
        used_q[alloc_slot_q] <= 1'b1;
        once_q[alloc_slot_q] <= item_q.run_once;
        done_q[alloc_slot_q] <= 1'b0;
      end
      if (cmd_i.stop_eval && stop_hit) begin
        used_q[scan_q] <= 1'b0;
        done_q[scan_q] <= 1'b0;
      end
      if (cmd_i.tick_commit && fire_once) begin
        done_q[scan_q] <= 1'b1;
      end
      if (cmd_i.tick_commit && fire) begin
        pend_valid_q <= 1'b1;
      end else if (cmd_i.push_pend) begin
        pend_valid_q <= 1'b0;
      end
      if (cmd_i.push_resp || cmd_i.push_pend || (cmd_i.tick_commit && fire && pend_valid_q)) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.op         = item_q.op;
  assign sts_o.full       = full;
  assign sts_o.need_div   = !item_q.run_once && (item_q.ticks != '0);
  assign sts_o.scan_last  = (scan_q == SlotW'(TASK_SLOTS - 1));
  assign sts_o.div_done   = (div_cnt_q == DivCntW'(TickW - 1));
  assign sts_o.tick_block = fire && pend_valid_q && !out_free;
  assign sts_o.out_free   = out_free;
  assign sts_o.pend_valid = pend_valid_q;

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

`ifndef SYNTHESIS
  a_push_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.push_resp || cmd_i.push_pend) |-> out_free)
    else $error("response pushed into an occupied output register");

  a_fire_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.tick_commit && fire && pend_valid_q) |-> out_free)
    else $error("fired result would overwrite the output register");

  a_reply_no_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push_resp |-> !pend_valid_q)
    else $error("reply issued while a fired result is pending");

  a_rem_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.ins_commit && !item_q.run_once && (item_q.ticks != '0))
    |-> (div_rem_q < item_q.ticks))
    else $error("start remainder not below its period");

  a_insert_one_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.ins_commit |=> ($countones(used_q) == $past($countones(used_q)) + 1))
    else $error("start did not take exactly one free slot");
`endif

endmodule

// ===== hw/rtl/software_timer_table.sv =====
// Top level of the software timer table: controller plus datapath.
// Depends on stt_pkg, stt_ctrl, stt_datapath.
//
//   port group   direction  payload     transfer when
//   in_*         request    in_req_i    in_valid_i && !in_stall_o
//   out_*        response   out_rsp_o   out_valid_o && !out_stall_i
//
// Requests are taken one at a time; a finished response may wait in the output register.
// Tick and stop scan all slots, one entry RAM read each; a tick writes back used entries.
// Start: a full table replies directly, a one-shot or zero delay entry is inserted, a
// periodic one after a bit-serial tick count remainder; an unused opcode gets no reply.
// Reset clears the slot flags and tick count at once; no clearing pass.
// A stalled output holds the tick scan, its flush or the reply until the register frees.
module software_timer_table #(
  parameter int unsigned TASK_SLOTS = stt_pkg::TaskSlotsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  stt_pkg::in_req_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output stt_pkg::out_rsp_t out_rsp_o
);

  stt_pkg::cmd_t cmd;
  stt_pkg::sts_t sts;

  stt_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  stt_datapath #(
    .TASK_SLOTS(TASK_SLOTS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_req_i   (in_req_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_rsp_o  (out_rsp_o)
  );

endmodule
